/* hdl/bis_pkg.sv */
// ----------------------------------------------------------------------------
// bis_pkg: shared types and constants of the bilinear image scaler
// Register indexes, command codes, sizes and the sequencer state type.
// ----------------------------------------------------------------------------
package bis_pkg;

	localparam int unsigned MAX_SRC_WIDTH_DEF  = 256;
	localparam int unsigned MAX_SRC_HEIGHT_DEF = 256;
	localparam int unsigned FRAC_BITS_DEF      = 8;

	localparam int unsigned POS_W    = 12;
	localparam int unsigned SRC_CW   = 13;
	localparam int unsigned TGT_CW   = 13;
	localparam int unsigned CFG_IW   = 2;
	localparam int unsigned CFG_DW   = 13;
	localparam int unsigned PIX_W    = 32;
	localparam int unsigned CH_W     = 8;
	localparam int unsigned MAX_TGT  = 4096;

	localparam logic [CFG_IW-1:0] REG_SRC_W = 2'd0;
	localparam logic [CFG_IW-1:0] REG_SRC_H = 2'd1;
	localparam logic [CFG_IW-1:0] REG_TGT_W = 2'd2;
	localparam logic [CFG_IW-1:0] REG_TGT_H = 2'd3;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_PRODUCE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_MAP,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_ACC,
		ST_OUT
	} seq_state_t;

endpackage

/* hdl/bis_ram.sv */
// ----------------------------------------------------------------------------
// bis_ram: generic single-port synchronous RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module bis_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

/* hdl/bis_divider.sv */
// ----------------------------------------------------------------------------
// bis_divider: restoring divider, one quotient bit per cycle
// Divides a NUM_W-bit numerator by a DEN_W-bit nonzero denominator.
// ----------------------------------------------------------------------------
module bis_divider #(
	parameter int unsigned NUM_W = 33,
	parameter int unsigned DEN_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);
	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = busy_q && (cnt_q == CNT_W'(1));
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

/* hdl/bilinear_image_scaler.sv */
// ----------------------------------------------------------------------------
// bilinear_image_scaler: bilinear BGRA image scaler over a frame store
// Loads source pixels and produces scaled destination pixels on request.
// ----------------------------------------------------------------------------
// A load request writes one pixel into the frame store and leaves busy low, so
// loads can follow back to back. A produce request runs a shared serial
// divider twice per axis (source position, then fraction), then reads the
// four neighbours through the single memory port and accumulates them. busy
// stays high until the sequence ends; the result is shown with done in ST_OUT,
// the last busy state, for one cycle only, and cannot be held.
module bilinear_image_scaler
	import bis_pkg::*;
#(
	parameter int unsigned MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
	parameter int unsigned MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_DEF,
	parameter int unsigned FRAC_BITS      = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         cmd,
	input  logic [bis_pkg::POS_W-1:0]    pos_x,
	input  logic [bis_pkg::POS_W-1:0]    pos_y,
	input  logic [7:0]                   in_blue,
	input  logic [7:0]                   in_green,
	input  logic [7:0]                   in_red,
	input  logic [7:0]                   in_alpha,
	input  logic                         cfg_we,
	input  logic [bis_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [bis_pkg::CFG_DW-1:0]   cfg_data,
	output logic                         done,
	output logic [bis_pkg::POS_W-1:0]    out_x,
	output logic [bis_pkg::POS_W-1:0]    out_y,
	output logic [7:0]                   out_blue,
	output logic [7:0]                   out_green,
	output logic [7:0]                   out_red,
	output logic [7:0]                   out_alpha
);
	localparam int unsigned XW    = $clog2(MAX_SRC_WIDTH);
	localparam int unsigned YW    = $clog2(MAX_SRC_HEIGHT);
	localparam int unsigned AW    = XW + YW;
	localparam int unsigned SZW   = SRC_CW;
	localparam int unsigned PRODW = POS_W + 1 + SZW;
	localparam int unsigned NUMW  = (PRODW > TGT_CW + FRAC_BITS) ? PRODW : TGT_CW + FRAC_BITS;
	localparam int unsigned ONEW  = FRAC_BITS + 1;
	localparam int unsigned WW    = 2 * ONEW;
	localparam int unsigned ACCW  = WW + CH_W + 2;

	logic [8:0]  src_w_q, src_h_q;
	logic [12:0] tgt_w_q, tgt_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= 9'd1;
			src_h_q <= 9'd1;
			tgt_w_q <= 13'd1;
			tgt_h_q <= 13'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_W: src_w_q <= cfg_data[8:0];
				REG_SRC_H: src_h_q <= cfg_data[8:0];
				REG_TGT_W: tgt_w_q <= cfg_data;
				REG_TGT_H: tgt_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [SZW-1:0] sw, sh;
	logic [13:0]    tw, th;

	always_comb begin
		sw = (src_w_q == 9'd0) ? SZW'(1) : SZW'(src_w_q);
		if (sw > SZW'(MAX_SRC_WIDTH)) sw = SZW'(MAX_SRC_WIDTH);
		sh = (src_h_q == 9'd0) ? SZW'(1) : SZW'(src_h_q);
		if (sh > SZW'(MAX_SRC_HEIGHT)) sh = SZW'(MAX_SRC_HEIGHT);
		tw = (tgt_w_q == 13'd0) ? 14'd1 : 14'(tgt_w_q);
		if (tw > 14'(MAX_TGT)) tw = 14'(MAX_TGT);
		th = (tgt_h_q == 13'd0) ? 14'd1 : 14'(tgt_h_q);
		if (th > 14'(MAX_TGT)) th = 14'(MAX_TGT);
	end

	seq_state_t state_q, state_d;
	logic           axis_q, phase_q;
	logic [POS_W-1:0] dx_q, dy_q;
	logic [PRODW-1:0] prod_q;
	logic             clamp_q;
	logic [XW-1:0]  c0_q, c1_q;
	logic [YW-1:0]  r0_q, r1_q;
	logic [ONEW-1:0] fx_q, fy_q;
	logic [WW-1:0]  w_q;
	logic [ACCW-1:0] acc_q [4];
	logic [1:0]     rd_q;

	logic            div_go, div_done;
	logic [NUMW-1:0] div_num, div_quo;
	logic [13:0]     div_den, div_rem;

	bis_divider #(.NUM_W(NUMW), .DEN_W(14)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo), .rem(div_rem)
	);

	logic [SZW-1:0] cur_s;
	logic [13:0]    cur_t;
	assign cur_s = axis_q ? sh : sw;
	assign cur_t = axis_q ? th : tw;

	logic             ram_we;
	logic [AW-1:0]    ram_addr;
	logic [PIX_W-1:0] ram_wdata, ram_rdata;

	bis_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SRC_WIDTH * MAX_SRC_HEIGHT)) u_store (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	logic [POS_W-1:0] lx, ly, px, py;
	always_comb begin
		lx = (13'(pos_x) >= sw) ? POS_W'(sw - 1'b1) : pos_x;
		ly = (13'(pos_y) >= sh) ? POS_W'(sh - 1'b1) : pos_y;
		px = (14'(pos_x) >= tw) ? POS_W'(tw - 1'b1) : pos_x;
		py = (14'(pos_y) >= th) ? POS_W'(th - 1'b1) : pos_y;
	end

	logic accept;
	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	logic [XW-1:0] ax;
	logic [YW-1:0] ay;
	always_comb begin
		case (rd_q)
			2'd0:    begin ax = c0_q; ay = r0_q; end
			2'd1:    begin ax = c1_q; ay = r0_q; end
			2'd2:    begin ax = c0_q; ay = r1_q; end
			default: begin ax = c1_q; ay = r1_q; end
		endcase
	end

	always_comb begin
		ram_we    = accept && (cmd == CMD_LOAD);
		ram_wdata = {in_alpha, in_red, in_green, in_blue};
		ram_addr  = ram_we ? {YW'(ly), XW'(lx)} : {ay, ax};
	end

	logic [ONEW-1:0] one_v;
	assign one_v = ONEW'(1) << FRAC_BITS;

	always_comb begin
		state_d = state_q;
		div_go  = 1'b0;
		div_num = NUMW'(prod_q);
		div_den = cur_t;
		case (state_q)
			ST_IDLE: if (accept && cmd == CMD_PRODUCE) state_d = ST_MUL;
			ST_MUL: begin
				div_go  = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: if (div_done) state_d = ST_MAP;
			ST_MAP: begin
				if (phase_q) begin
					state_d = axis_q ? ST_RD0 : ST_MUL;
				end else begin
					div_go  = 1'b1;
					div_num = NUMW'({div_rem, FRAC_BITS'(0)});
					state_d = ST_DIV;
				end
			end
			ST_RD0: state_d = ST_RD1;
			ST_RD1: state_d = ST_RD2;
			ST_RD2: state_d = ST_RD3;
			ST_RD3: state_d = ST_ACC;
			ST_ACC: state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	logic [SZW-1:0]  qn;
	logic            qclamp;
	logic [ONEW-1:0] fsel;
	logic [WW-1:0]   w_next;
	logic [ONEW-1:0] wy, wx;

	always_comb begin
		qclamp = (div_quo == '0) || (div_quo > NUMW'(cur_s));
		qn = (div_quo == '0) ? SZW'(1) : ((div_quo > NUMW'(cur_s)) ? cur_s : SZW'(div_quo));
		fsel = ONEW'(div_quo);
		wy = rd_q[1] ? fy_q : (one_v - fy_q);
		wx = rd_q[0] ? fx_q : (one_v - fx_q);
		w_next = WW'(wy) * WW'(wx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q  <= 1'b0;
			phase_q <= 1'b0;
			rd_q    <= 2'd0;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) begin axis_q <= 1'b0; phase_q <= 1'b0; end
				ST_MAP: begin
					phase_q <= ~phase_q;
					if (phase_q) axis_q <= 1'b1;
					rd_q <= 2'd0;
				end
				ST_RD0, ST_RD1, ST_RD2, ST_RD3: rd_q <= rd_q + 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			dx_q <= px;
			dy_q <= py;
			prod_q <= PRODW'(13'(px) + 13'd1) * PRODW'(sw);
		end
		if (state_q == ST_MAP && phase_q && !axis_q) begin
			prod_q <= PRODW'(13'(dy_q) + 13'd1) * PRODW'(sh);
		end
		if (state_q == ST_MAP && !phase_q) begin
			clamp_q <= qclamp;
			if (!axis_q) begin
				c0_q <= XW'(qn - 1'b1);
				c1_q <= (qn < sw) ? XW'(qn) : XW'(qn - 1'b1);
			end else begin
				r0_q <= YW'(qn - 1'b1);
				r1_q <= (qn < sh) ? YW'(qn) : YW'(qn - 1'b1);
			end
		end
		// fraction is zero where the position was clamped
		if (state_q == ST_MAP && phase_q) begin
			if (!axis_q) fx_q <= clamp_q ? '0 : fsel;
			else fy_q <= clamp_q ? '0 : fsel;
		end
		if (state_q == ST_RD0 || state_q == ST_RD1 || state_q == ST_RD2 ||
		    state_q == ST_RD3) begin
			w_q <= w_next;
		end
		if (state_q == ST_RD0) begin
			for (int c = 0; c < 4; c++) acc_q[c] <= '0;
		end
		if (state_q == ST_RD1 || state_q == ST_RD2 || state_q == ST_RD3 ||
		    state_q == ST_ACC) begin
			for (int c = 0; c < 4; c++) begin
				acc_q[c] <= acc_q[c] + ACCW'(ram_rdata[c*CH_W +: CH_W]) * ACCW'(w_q);
			end
		end
	end

	assign done      = (state_q == ST_OUT);
	assign out_x     = dx_q;
	assign out_y     = dy_q;
	assign out_blue  = acc_q[0][2*FRAC_BITS +: CH_W];
	assign out_green = acc_q[1][2*FRAC_BITS +: CH_W];
	assign out_red   = acc_q[2][2*FRAC_BITS +: CH_W];
	assign out_alpha = acc_q[3][2*FRAC_BITS +: CH_W];
endmodule
